@@ src/ihex_pkg.sv @@
// Shared types, constants and character helpers for the Intel HEX encoder.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package ihex_pkg;

  localparam int ADDR_W           = 32;
  localparam int LEN_W            = 29;
  localparam int CONS_W           = 30;
  localparam int CFG_IDX_W        = 1;
  localparam int RECORD_BYTES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LENGTH = 1'd1;

  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_F     = 8'h46;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] HEX_A_OFS = 8'h37;

  localparam logic [7:0] EXT_TYPE_SUM = 8'h06;
  localparam logic [4:0] EOF_LAST_POS = 5'd12;

  typedef enum logic [2:0] {
    PH_EXT,
    PH_HDR,
    PH_DATA,
    PH_CLOSE,
    PH_EOF
  } phase_t;

  typedef struct packed {
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        ext_chk;
    logic [7:0]        rec_chk;
    logic              eof_only;
    logic              ext;
    logic              hdr;
    logic              close;
    logic              eof;
  } cmd_t;

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CHR_ZERO + {4'h0, v};
    end else begin
      r = HEX_A_OFS + {4'h0, v};
    end
    return r;
  endfunction

  function automatic logic [7:0] eof_char(logic [4:0] pos);
    logic [7:0] r;
    case (pos)
      5'd0:            r = CHR_COLON;
      5'd8:            r = CHR_ONE;
      5'd9, 5'd10:     r = CHR_F;
      5'd11:           r = CHR_CR;
      5'd12:           r = CHR_LF;
      default:         r = CHR_ZERO;
    endcase
    return r;
  endfunction

endpackage

@@ src/ihex_front.sv @@
// Front end: configuration registers, address and record tracking, checksums.
// Classifies each accepted byte into a command for the queue. Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_front #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ihex_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_data,
  input  logic                           q_full,
  output logic                           q_push,
  output ihex_pkg::cmd_t                 q_cmd
);

  localparam int BIR_W = $clog2(RECORD_BYTES + 1);
  localparam logic [BIR_W-1:0] RB_CNT = BIR_W'(RECORD_BYTES);
  localparam logic [7:0] RB_BYTE = 8'(RECORD_BYTES);

  logic [ihex_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [ihex_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [ihex_pkg::CONS_W-1:0] cons_r, cons_nxt;
  logic [BIR_W-1:0]            bir_r, bir_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic                        first_r, first_nxt;
  logic                        fin_r, fin_nxt;

  logic                        accept;
  logic                        at_start;
  logic                        reached;
  logic [BIR_W-1:0]            bir_inc;
  logic [ihex_pkg::CONS_W-1:0] cons_inc;
  logic [7:0]                  sum_base;
  logic [7:0]                  sum_new;
  logic                        close_c;
  logic                        eof_c;

  assign cfg_ready = 1'b1;
  assign in_tready = fin_r | ~q_full;
  assign accept    = in_tvalid & in_tready;

  assign at_start = (bir_r == '0);
  assign reached  = (cons_r >= {1'b0, len_r});
  assign bir_inc  = bir_r + 1'b1;
  assign cons_inc = cons_r + 1'b1;
  assign sum_base = at_start ? (RB_BYTE + addr_r[15:8] + addr_r[7:0]) : sum_r;
  assign sum_new  = sum_base + in_data;
  assign close_c  = (bir_inc == RB_CNT);
  assign eof_c    = close_c & (cons_inc >= {1'b0, len_r});

  always_comb begin
    q_cmd.data     = in_data;
    q_cmd.addr     = addr_r;
    q_cmd.ext_chk  = 8'h00 - (ihex_pkg::EXT_TYPE_SUM + addr_r[31:24] + addr_r[23:16]);
    q_cmd.rec_chk  = 8'h00 - sum_new;
    q_cmd.eof_only = at_start & reached;
    q_cmd.ext      = at_start & (first_r | (addr_r[15:0] == 16'h0000));
    q_cmd.hdr      = at_start;
    q_cmd.close    = close_c;
    q_cmd.eof      = eof_c;
    q_push         = accept & ~fin_r;
  end

  always_comb begin
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    cons_nxt  = cons_r;
    bir_nxt   = bir_r;
    sum_nxt   = sum_r;
    first_nxt = first_r;
    fin_nxt   = fin_r;
    if (accept && !fin_r) begin
      if (at_start && reached) begin
        fin_nxt = 1'b1;
      end else begin
        if (at_start) begin
          first_nxt = 1'b0;
        end
        addr_nxt = addr_r + 1'b1;
        cons_nxt = cons_inc;
        bir_nxt  = close_c ? '0 : bir_inc;
        sum_nxt  = sum_new;
        fin_nxt  = eof_c;
      end
    end
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ihex_pkg::REG_BASE_ADDRESS: begin
          addr_nxt  = {cfg_data[ihex_pkg::ADDR_W-1:4], 4'h0};
          cons_nxt  = '0;
          bir_nxt   = '0;
          sum_nxt   = 8'h00;
          first_nxt = 1'b1;
          fin_nxt   = 1'b0;
        end
        ihex_pkg::REG_IMAGE_LENGTH: begin
          len_nxt = cfg_data[ihex_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      len_r   <= ihex_pkg::LEN_W'(16);
      cons_r  <= '0;
      bir_r   <= '0;
      sum_r   <= 8'h00;
      first_r <= 1'b1;
      fin_r   <= 1'b0;
    end else begin
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      cons_r  <= cons_nxt;
      bir_r   <= bir_nxt;
      sum_r   <= sum_nxt;
      first_r <= first_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

@@ src/ihex_queue.sv @@
// Short command queue between the front end and the character sequencer.
// Register based, one push and one pop per cycle. Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_queue #(
  parameter int DEPTH = ihex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ihex_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output ihex_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ihex_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/ihex_back.sv @@
// Back end: character sequencer that expands one command into HEX text, one
// character per cycle unless stalled, into a registered output stage. Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_back #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ihex_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic [0:0]     out_tuser
);

  localparam logic [7:0] RB_BYTE = 8'(RECORD_BYTES);

  ihex_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]       pos_r, pos_nxt;
  logic             busy_r, busy_nxt;
  ihex_pkg::cmd_t   cmd_r, cmd_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       ochar_r;
  logic             olast_r;
  logic             odone_r;

  logic             adv;
  logic             phase_end;
  logic             cmd_done;
  logic             load;
  logic [7:0]       char_c;
  logic             done_c;
  ihex_pkg::phase_t after_c;
  logic [55:0]      ext_word;
  logic [31:0]      hdr_word;
  logic [3:0]       ext_nib_idx;
  logic [2:0]       hdr_nib_idx;
  logic [55:0]      ext_shift;
  logic [31:0]      hdr_shift;

  function automatic ihex_pkg::phase_t start_phase(ihex_pkg::cmd_t c);
    ihex_pkg::phase_t p;
    if (c.eof_only) begin
      p = ihex_pkg::PH_EOF;
    end else if (c.ext) begin
      p = ihex_pkg::PH_EXT;
    end else if (c.hdr) begin
      p = ihex_pkg::PH_HDR;
    end else begin
      p = ihex_pkg::PH_DATA;
    end
    return p;
  endfunction

  assign ext_word    = {8'h02, 8'h00, 8'h00, 8'h04, cmd_r.addr[31:16], cmd_r.ext_chk};
  assign hdr_word    = {RB_BYTE, cmd_r.addr[15:0], 8'h00};
  assign ext_nib_idx = 4'(pos_r - 5'd1);
  assign hdr_nib_idx = 3'(pos_r - 5'd1);
  assign ext_shift   = ext_word >> {(4'd13 - ext_nib_idx), 2'b00};
  assign hdr_shift   = hdr_word >> {(3'd7 - hdr_nib_idx), 2'b00};

  always_comb begin
    char_c    = ihex_pkg::CHR_COLON;
    done_c    = 1'b0;
    phase_end = 1'b0;
    after_c   = ihex_pkg::PH_DATA;
    cmd_done  = 1'b0;
    case (phase_r)
      ihex_pkg::PH_EXT: begin
        phase_end = (pos_r == 5'd16);
        after_c   = ihex_pkg::PH_HDR;
        if (pos_r == 5'd15) begin
          char_c = ihex_pkg::CHR_CR;
        end else if (pos_r == 5'd16) begin
          char_c = ihex_pkg::CHR_LF;
        end else if (pos_r != 5'd0) begin
          char_c = ihex_pkg::hex_char(ext_shift[3:0]);
        end
      end
      ihex_pkg::PH_HDR: begin
        phase_end = (pos_r == 5'd8);
        after_c   = ihex_pkg::PH_DATA;
        if (pos_r != 5'd0) begin
          char_c = ihex_pkg::hex_char(hdr_shift[3:0]);
        end
      end
      ihex_pkg::PH_DATA: begin
        phase_end = (pos_r == 5'd1);
        after_c   = ihex_pkg::PH_CLOSE;
        cmd_done  = phase_end & ~cmd_r.close;
        char_c    = ihex_pkg::hex_char(pos_r[0] ? cmd_r.data[3:0] : cmd_r.data[7:4]);
      end
      ihex_pkg::PH_CLOSE: begin
        phase_end = (pos_r == 5'd3);
        after_c   = ihex_pkg::PH_EOF;
        cmd_done  = phase_end & ~cmd_r.eof;
        case (pos_r[1:0])
          2'd0:    char_c = ihex_pkg::hex_char(cmd_r.rec_chk[7:4]);
          2'd1:    char_c = ihex_pkg::hex_char(cmd_r.rec_chk[3:0]);
          2'd2:    char_c = ihex_pkg::CHR_CR;
          default: char_c = ihex_pkg::CHR_LF;
        endcase
      end
      ihex_pkg::PH_EOF: begin
        phase_end = (pos_r == ihex_pkg::EOF_LAST_POS);
        after_c   = ihex_pkg::PH_EOF;
        cmd_done  = phase_end;
        done_c    = phase_end;
        char_c    = ihex_pkg::eof_char(pos_r);
      end
      default: begin
      end
    endcase
  end

  assign adv   = busy_r & (~ovalid_r | out_tready);
  assign load  = ~busy_r | (adv & cmd_done);
  assign q_pop = load & q_valid;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    busy_nxt  = busy_r;
    cmd_nxt   = cmd_r;
    if (load) begin
      busy_nxt = q_valid;
      if (q_valid) begin
        cmd_nxt   = q_cmd;
        phase_nxt = start_phase(q_cmd);
        pos_nxt   = 5'd0;
      end
    end else if (adv) begin
      if (phase_end) begin
        phase_nxt = after_c;
        pos_nxt   = 5'd0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
    if (adv) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (adv) begin
      ochar_r <= char_c;
      olast_r <= cmd_done;
      odone_r <= done_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ihex_pkg::PH_DATA;
      pos_r    <= 5'd0;
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid   = ovalid_r;
  assign out_tdata    = ochar_r;
  assign out_tlast    = olast_r;
  assign out_tuser[0] = odone_r;

endmodule

@@ src/intel_hex_record_encoder.sv @@
// Top level of the Intel HEX encoder: front end, command queue, sequencer.
// Depends on ihex_pkg, ihex_front, ihex_queue and ihex_back.
//
//   channel  dir  handshake              payload
//   cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//   in       in   in_tvalid/in_tready    in_tdata: data_byte
//   out      out  out_tvalid/out_tready  out_tdata: ascii_char, tlast, tuser
//
// One character leaves per cycle from the output register while out_tready
// is high; a mid-record byte gives two characters, and one opening an
// extended address record also emits it and the header. Bytes enter one
// per cycle while the queue has room. Reset is synchronous, active low; no
// clearing pass. Output stalls back up through the queue into in_tready.
`timescale 1ns / 1ps

module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF,
  parameter int QUEUE_DEPTH  = ihex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ihex_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] ascii_char
  output logic                           out_tlast,  // last_of_run
  output logic [0:0]                     out_tuser   // [0] file_done
);

  logic           q_full;
  logic           q_push;
  ihex_pkg::cmd_t push_cmd;
  logic           q_pop;
  logic           head_valid;
  ihex_pkg::cmd_t head_cmd;

  ihex_front #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_data  (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ihex_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  ihex_back #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule
